// ----- src/pic_pkg.sv -----
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and constants of the prioritised interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int unsigned SOURCE_COUNT = 5;
  localparam int unsigned CNT_W        = 2;
  localparam int unsigned VECTOR_W     = 7;

  localparam logic [VECTOR_W-1:0] VECTOR_BASE = 7'h40;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_REQUEST = 3'd2,
    OP_SERVICE = 3'd3,
    OP_TICK    = 3'd4,
    OP_ENABLE  = 3'd5,
    OP_DISABLE = 3'd6,
    OP_HALT    = 3'd7
  } op_t;

  localparam logic SEL_REQUEST = 1'b0;
  localparam logic SEL_ENABLE  = 1'b1;

  typedef struct packed {
    logic exec;
  } pic_cmd_t;

  typedef struct packed {
    logic result_valid;
  } pic_status_t;

endpackage

// ----- src/pic_ctrl.sv -----
// ----------------------------------------------------------------------------
// pic_ctrl
// Handshake controller: accepts a request whenever the result register is
// free or being emptied, and tracks whether that register holds a result.
// ----------------------------------------------------------------------------
module pic_ctrl
  import pic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output pic_cmd_t    cmd,
  output pic_status_t status
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready  = (state_r == ST_EMPTY) || out_tready;
  assign out_tvalid = (state_r == ST_FULL);
  assign cmd.exec   = in_tvalid && in_tready;
  assign status.result_valid = (state_r == ST_FULL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (cmd.exec) begin
          state_nxt = ST_FULL;
        end
      end
      ST_FULL: begin
        if (out_tready && !cmd.exec) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/pic_datapath.sv -----
// ----------------------------------------------------------------------------
// pic_datapath
// Flag registers, switch countdowns, priority picker and result register.
// ----------------------------------------------------------------------------
module pic_datapath
  import pic_pkg::*;
#(
  parameter int unsigned SWITCH_DELAY = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pic_cmd_t                cmd,
  input  logic [2:0]              op,
  input  logic                    reg_select,
  input  logic [7:0]              write_data,
  input  logic [SOURCE_COUNT-1:0] request_lines,
  output logic [7:0]              read_data,
  output logic                    taken,
  output logic [VECTOR_W-1:0]     vector,
  output logic                    master_enabled,
  output logic                    halted
);

  localparam logic [CNT_W-1:0] DELAY_LOAD = CNT_W'(SWITCH_DELAY);

  logic [7:0]          req_r, req_nxt;
  logic [7:0]          ena_r, ena_nxt;
  logic                ime_r, ime_nxt;
  logic [CNT_W-1:0]    ecnt_r, ecnt_nxt;
  logic [CNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic                halt_r, halt_nxt;
  logic [7:0]          rdata_r, rdata_nxt;
  logic                taken_r, taken_nxt;
  logic [VECTOR_W-1:0] vector_r, vector_nxt;

  logic [SOURCE_COUNT-1:0] ready;
  logic                    found;
  logic [2:0]              pick;

  assign ready = req_r[SOURCE_COUNT-1:0] & ena_r[SOURCE_COUNT-1:0];

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = SOURCE_COUNT - 1; i >= 0; i--) begin
      if (ready[i]) begin
        found = 1'b1;
        pick  = 3'(i);
      end
    end
  end

  always_comb begin
    req_nxt    = req_r;
    ena_nxt    = ena_r;
    ime_nxt    = ime_r;
    ecnt_nxt   = ecnt_r;
    dcnt_nxt   = dcnt_r;
    halt_nxt   = halt_r;
    rdata_nxt  = '0;
    taken_nxt  = 1'b0;
    vector_nxt = '0;
    unique case (op_t'(op))
      OP_WRITE: begin
        if (reg_select == SEL_REQUEST) begin
          req_nxt = write_data;
        end else begin
          ena_nxt = write_data;
        end
      end
      OP_READ: begin
        rdata_nxt = (reg_select == SEL_REQUEST) ? req_r : ena_r;
      end
      OP_REQUEST: begin
        halt_nxt = 1'b0;
        req_nxt  = req_r | {3'b000, request_lines};
      end
      OP_SERVICE: begin
        if (ime_r && found) begin
          req_nxt[pick] = 1'b0;
          ime_nxt       = 1'b0;
          taken_nxt     = 1'b1;
          vector_nxt    = VECTOR_BASE + {1'b0, pick, 3'b000};
        end
      end
      OP_TICK: begin
        if (dcnt_r != '0) begin
          dcnt_nxt = dcnt_r - CNT_W'(1);
          if (dcnt_r == CNT_W'(1)) begin
            ime_nxt = 1'b0;
          end
        end
        if (ecnt_r != '0) begin
          ecnt_nxt = ecnt_r - CNT_W'(1);
          if (ecnt_r == CNT_W'(1)) begin
            ime_nxt = 1'b1;
          end
        end
      end
      OP_ENABLE: begin
        ecnt_nxt = DELAY_LOAD;
        dcnt_nxt = '0;
      end
      OP_DISABLE: begin
        dcnt_nxt = DELAY_LOAD;
        ecnt_nxt = '0;
      end
      OP_HALT: begin
        halt_nxt = 1'b1;
      end
      default: begin
        halt_nxt = halt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r  <= '0;
      ena_r  <= '0;
      ime_r  <= 1'b0;
      ecnt_r <= '0;
      dcnt_r <= '0;
      halt_r <= 1'b0;
    end else if (cmd.exec) begin
      req_r  <= req_nxt;
      ena_r  <= ena_nxt;
      ime_r  <= ime_nxt;
      ecnt_r <= ecnt_nxt;
      dcnt_r <= dcnt_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata_r  <= rdata_nxt;
      taken_r  <= taken_nxt;
      vector_r <= vector_nxt;
    end
  end

  assign read_data      = rdata_r;
  assign taken          = taken_r;
  assign vector         = vector_r;
  assign master_enabled = ime_r;
  assign halted         = halt_r;

endmodule

// ----- src/prioritized_interrupt_controller.sv -----
// ----------------------------------------------------------------------------
// prioritized_interrupt_controller
// Five-source interrupt controller with delayed master enable and halt flag.
// ----------------------------------------------------------------------------
// Each request on the input stream carries one operation in in_tuser and its
// operands in in_tdata. Exactly one result follows every request on the
// output stream: the byte read, the dispatch flag and vector, and the master
// enable and halt flags as they stand after the operation.
// A request is executed in the cycle it is accepted and its result appears
// on the output in the next cycle. The block takes one request per cycle,
// limited only by the single result register.
// While the receiver stalls, the result is held and a new request is still
// accepted in the cycle the held result is taken.
// Reset clears all flags, countdowns and the result register's valid state.
// Enable and disable act after SWITCH_DELAY tick operations.
// ----------------------------------------------------------------------------
module prioritized_interrupt_controller
  import pic_pkg::*;
#(
  parameter int unsigned SWITCH_DELAY = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // write_data[7:0], request_lines[12:8], zero
  input  logic [3:0]  in_tuser,   // op[2:0], reg_select[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // read_data[7:0], taken[8], vector[15:9],
                                  // master_enabled[16], halted[17], zero
);

  pic_cmd_t            cmd;
  pic_status_t         status;
  logic [7:0]          read_data;
  logic                taken;
  logic [VECTOR_W-1:0] vector;
  logic                master_enabled;
  logic                halted;

  pic_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  pic_datapath #(
    .SWITCH_DELAY (SWITCH_DELAY)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .op             (in_tuser[2:0]),
    .reg_select     (in_tuser[3]),
    .write_data     (in_tdata[7:0]),
    .request_lines  (in_tdata[12:8]),
    .read_data      (read_data),
    .taken          (taken),
    .vector         (vector),
    .master_enabled (master_enabled),
    .halted         (halted)
  );

  assign out_tdata = {6'b000000, halted, master_enabled, vector, taken, read_data};

  a_ready_follows_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!status.result_valid || out_tready))
    else $error("input ready does not follow the result register state");

  a_taken_drops_master: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> !out_tdata[16])
    else $error("dispatch left the master enable set");

  a_vector_iff_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8] == (out_tdata[15:9] != '0)))
    else $error("vector and dispatch flag disagree");

  a_read_excludes_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> (out_tdata[7:0] == 8'h00))
    else $error("dispatch result carries read data");

endmodule

// ----- sim/prioritized_interrupt_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prioritized_interrupt_controller_tb
// Self-checking testbench for the five-source interrupt controller.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver on the input stream, and a
// clocked monitor on the output stream compares every result with the oldest
// prediction. The predictor keeps its own copy of the request and enable
// bytes, master enable, switch countdowns and halt flag. A short directed
// sequence is followed by random operations and well-formed enable and
// service sequences. Both sides idle at random, and once the receiver stalls
// for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module prioritized_interrupt_controller_tb;
  import pic_pkg::*;

  localparam int unsigned SWITCH_DELAY   = 2;
  localparam int          RANDOM_ITEMS   = 1700;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          LONG_STALL     = 80;
  localparam int          MAX_REPORTS    = 10;

  typedef struct {
    op_t        op;
    logic       sel;
    logic [7:0] wdata;
    logic [4:0] lines;
  } irq_op_t;

  typedef struct packed {
    logic       halted;
    logic       master_enabled;
    logic [6:0] vector;
    logic       taken;
    logic [7:0] read_data;
  } irq_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // write_data[7:0], request_lines[12:8], zero
  logic [3:0]  in_tuser = '0;   // op[2:0], reg_select[3]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // read_data[7:0], taken[8], vector[15:9],
                                // master_enabled[16], halted[17], zero

  prioritized_interrupt_controller #(
    .SWITCH_DELAY(SWITCH_DELAY)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  irq_op_t     pending_ops[$];
  irq_result_t expected_results[$];
  irq_op_t     offered_op;

  logic [7:0] irq_flags = '0;
  logic [7:0] irq_mask = '0;
  logic       ime = 1'b0;
  logic [1:0] ime_on_count = '0;
  logic [1:0] ime_off_count = '0;
  logic       halt_st = 1'b0;

  int send_idle_pct = 13;
  int recv_idle_pct = 70;
  int n_directed = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_taken = 0;
  int n_mismatch = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  logic [4:0] vectors_hit = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic irq_result_t step_controller(irq_op_t it);
    irq_result_t r;
    logic [7:0]  ready;
    r = '0;
    case (it.op)
      OP_WRITE: begin
        if (it.sel == SEL_REQUEST) irq_flags = it.wdata;
        else irq_mask = it.wdata;
      end
      OP_READ: begin
        r.read_data = (it.sel == SEL_REQUEST) ? irq_flags : irq_mask;
      end
      OP_REQUEST: begin
        halt_st = 1'b0;
        irq_flags = irq_flags | {3'b000, it.lines};
      end
      OP_SERVICE: begin
        if (ime) begin
          ready = irq_flags & irq_mask;
          for (int i = 0; i < SOURCE_COUNT; i++) begin
            if (ready[i] && !r.taken) begin
              irq_flags[i] = 1'b0;
              ime = 1'b0;
              r.taken = 1'b1;
              r.vector = VECTOR_BASE + 7'(8 * i);
            end
          end
        end
      end
      OP_TICK: begin
        // A pending disable is applied before a pending enable.
        if (ime_off_count != 0) begin
          if (ime_off_count == 2'd1) ime = 1'b0;
          ime_off_count = ime_off_count - 2'd1;
        end
        if (ime_on_count != 0) begin
          if (ime_on_count == 2'd1) ime = 1'b1;
          ime_on_count = ime_on_count - 2'd1;
        end
      end
      OP_ENABLE: begin
        ime_on_count = CNT_W'(SWITCH_DELAY);
        ime_off_count = '0;
      end
      OP_DISABLE: begin
        ime_off_count = CNT_W'(SWITCH_DELAY);
        ime_on_count = '0;
      end
      default: begin
        halt_st = 1'b1;
      end
    endcase
    r.master_enabled = ime;
    r.halted = halt_st;
    return r;
  endfunction

  task automatic add_op(op_t op, logic sel, logic [7:0] wdata, logic [4:0] lines);
    irq_op_t it;
    it.op = op;
    it.sel = sel;
    it.wdata = wdata;
    it.lines = lines;
    pending_ops.push_back(it);
  endtask

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 10) return OP_WRITE;
    if (r < 20) return OP_READ;
    if (r < 35) return OP_REQUEST;
    if (r < 55) return OP_SERVICE;
    if (r < 75) return OP_TICK;
    if (r < 85) return OP_ENABLE;
    if (r < 92) return OP_DISABLE;
    return OP_HALT;
  endfunction

  // Driver: a new request is offered only once the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(step_controller(offered_op));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {3'b000, offered_op.lines, offered_op.wdata};
          in_tuser <= {offered_op.sel, offered_op.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && n_accepted >= 300) begin
      stall_done <= 1'b1;
      stall_left <= LONG_STALL;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    irq_result_t got;
    irq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[17:0];
      n_checked++;
      if (got.taken) begin
        n_taken++;
        vectors_hit[3'((got.vector - VECTOR_BASE) >> 3)] = 1'b1;
      end
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("[%0t] unexpected result: rd=%02h taken=%0b vec=%02h ime=%0b halt=%0b",
                   $realtime, got.read_data, got.taken, got.vector,
                   got.master_enabled, got.halted);
      end else begin
        want = expected_results.pop_front();
        if (got.read_data != want.read_data || got.taken != want.taken ||
            got.vector != want.vector || got.master_enabled != want.master_enabled ||
            got.halted != want.halted) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("[%0t] result %0d: expected rd=%02h taken=%0b vec=%02h ",
                     $realtime, n_checked, want.read_data, want.taken, want.vector,
                     "ime=%0b halt=%0b, ", want.master_enabled, want.halted,
                     "got rd=%02h taken=%0b vec=%02h ", got.read_data, got.taken,
                     got.vector, "ime=%0b halt=%0b", got.master_enabled, got.halted);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("** prioritized_interrupt_controller: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    // Full bytes are stored and read back; upper request bits never dispatch.
    add_op(OP_READ,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_WRITE,   SEL_ENABLE,  8'hFF, 5'h1F);
    add_op(OP_READ,    SEL_ENABLE,  8'h00, 5'h00);
    add_op(OP_WRITE,   SEL_REQUEST, 8'hE0, 5'h00);
    add_op(OP_READ,    SEL_REQUEST, 8'hFF, 5'h1F);
    add_op(OP_SERVICE, SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_HALT,    SEL_ENABLE,  8'h00, 5'h00);
    add_op(OP_REQUEST, SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_ENABLE,  SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_TICK,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_TICK,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_SERVICE, SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_REQUEST, SEL_REQUEST, 8'h00, 5'h1F);
    add_op(OP_SERVICE, SEL_REQUEST, 8'h00, 5'h00);
    // A disable issued while an enable is counting down cancels it.
    add_op(OP_ENABLE,  SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_TICK,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_DISABLE, SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_TICK,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_TICK,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_ENABLE,  SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_TICK,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_TICK,    SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_WRITE,   SEL_ENABLE,  8'h10, 5'h00);
    add_op(OP_SERVICE, SEL_REQUEST, 8'h00, 5'h00);
    add_op(OP_WRITE,   SEL_REQUEST, 8'h00, 5'h00);
    n_directed = pending_ops.size();

    // Mostly single random operations, with bursts that enable and then service.
    while (pending_ops.size() < n_directed + RANDOM_ITEMS) begin
      r = $urandom_range(9);
      if (r < 3) begin
        add_op(OP_ENABLE,  1'($urandom), 8'($urandom), 5'($urandom));
        add_op(OP_TICK,    1'($urandom), 8'($urandom), 5'($urandom));
        add_op(OP_TICK,    1'($urandom), 8'($urandom), 5'($urandom));
        add_op(OP_REQUEST, 1'($urandom), 8'($urandom), 5'($urandom));
        add_op(OP_SERVICE, 1'($urandom), 8'($urandom), 5'($urandom));
      end else if (r == 3) begin
        add_op(OP_WRITE, SEL_ENABLE, 8'($urandom), 5'($urandom));
      end else begin
        add_op(pick_op(), 1'($urandom), 8'($urandom), 5'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_directed + RANDOM_ITEMS / 3) @(posedge clk);
    send_idle_pct = 70;
    recv_idle_pct = 13;
    while (n_accepted < n_directed + 2 * RANDOM_ITEMS / 3) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (pending_ops.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) n_mismatch++;

    $display("Run covered %0d requests (%0d directed) and checked %0d results.",
             n_accepted, n_directed, n_checked);
    $display("%0d interrupts were dispatched; ", n_taken,
             "vectors seen (bit per source): %05b; %0d mismatches.",
             vectors_hit, n_mismatch);
    if (n_mismatch == 0) begin
      $display("** prioritized_interrupt_controller: PASSED **");
    end else begin
      $display("** prioritized_interrupt_controller: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pic_pkg.sv
src/pic_ctrl.sv
src/pic_datapath.sv
src/prioritized_interrupt_controller.sv
sim/prioritized_interrupt_controller_tb.sv
